[sv/psp_pkg.sv]
// Shared constants, register codes and divider stage type for the
// point to screen projection block. No dependencies.
`default_nettype none
package psp_pkg;

  localparam int FRAC_BITS = 16;
  // quotient bits kept by the divider; anything wider saturates anyway
  localparam int QB = FRAC_BITS + 18;
  localparam int WW = 31;
  localparam int TW = QB + 17;
  localparam logic [QB-1:0] Q_LIMIT = QB'(1) << (FRAC_BITS + 17);
  // input, product, magnitude, divider steps, scale, output
  localparam int NS = QB + 5;

  localparam logic [2:0] REG_X_SCALE  = 3'd0;
  localparam logic [2:0] REG_X_OFFSET = 3'd1;
  localparam logic [2:0] REG_Y_SCALE  = 3'd2;
  localparam logic [2:0] REG_Y_OFFSET = 3'd3;
  localparam logic [2:0] REG_NEAR_W   = 3'd4;
  localparam logic [2:0] REG_WIDTH    = 3'd5;
  localparam logic [2:0] REG_HEIGHT   = 3'd6;

  typedef struct packed {
    logic [WW-1:0] r;
    logic [QB-1:0] low;
    logic [QB-1:0] q;
    logic [WW-1:0] w;
    logic          neg;
    logic          ovf;
  } psp_div_t;

endpackage
`default_nettype wire

[sv/psp_divider.sv]
// Pipelined restoring divider, one quotient bit per stage.
// Depends on psp_pkg; stage enables come from the top level.
`default_nettype none
module psp_divider import psp_pkg::*; (
  input  wire logic          clk,
  input  wire logic [QB-1:0] en,
  input  wire psp_div_t      din,
  output psp_div_t           dout
);

  psp_div_t st [QB];

  function automatic psp_div_t div_step(input psp_div_t s);
    psp_div_t      o;
    logic [WW:0]   r2;
    logic          b;
    o  = s;
    b  = s.low[QB-1];
    r2 = {s.r, b};
    o.low = {s.low[QB-2:0], 1'b0};
    if (r2 >= {1'b0, s.w}) begin
      o.r = WW'(r2 - {1'b0, s.w});
      o.q = {s.q[QB-2:0], 1'b1};
    end else begin
      o.r = r2[WW-1:0];
      o.q = {s.q[QB-2:0], 1'b0};
    end
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (en[0]) st[0] <= div_step(din);
    for (int k = 1; k < QB; k++) begin
      if (en[k]) st[k] <= div_step(st[k-1]);
    end
  end

  assign dout = st[QB-1];

endmodule
`default_nettype wire

[sv/point_to_screen_projection_top.sv]
// Point to screen projection: top level with config registers and pipeline.
// Depends on psp_pkg and psp_divider.
//
// One point enters per cycle unless in_stall is high; each result passes the
// input, product, magnitude, divider, scale and output registers, the depth
// being set by the one-bit-per-stage divider for each axis. Every stage
// holds its item until the next stage frees, so idle slots are filled while
// a result waits at the output.
`default_nettype none
module point_to_screen_projection_top import psp_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_en,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  input  wire logic signed [31:0] pos_z,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      pixel_x,
  output logic signed [15:0]      pixel_y
);

  logic signed [31:0] x_scale, x_offset, y_scale, y_offset;
  logic [30:0]        near_w;
  logic [13:0]        screen_width, screen_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_scale       <= 32'sd65536;
      x_offset      <= '0;
      y_scale       <= 32'sd65536;
      y_offset      <= '0;
      near_w        <= 31'd6554;
      screen_width  <= 14'd1920;
      screen_height <= 14'd1080;
    end else if (cfg_en) begin
      case (cfg_index)
        REG_X_SCALE:  x_scale       <= cfg_data;
        REG_X_OFFSET: x_offset      <= cfg_data;
        REG_Y_SCALE:  y_scale       <= cfg_data;
        REG_Y_OFFSET: y_offset      <= cfg_data;
        REG_NEAR_W:   near_w        <= cfg_data[30:0];
        REG_WIDTH:    screen_width  <= cfg_data[13:0];
        REG_HEIGHT:   screen_height <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  logic [NS-1:0] vld;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = !out_stall;
    for (int k = NS - 1; k >= 0; k--) en[k] = !vld[k] || en[k+1];
  end

  assign in_stall  = !en[0];
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // stage 0: capture point, pick w
  logic signed [31:0] s0_px, s0_py, s0_pz;
  logic [WW-1:0]      s0_w;
  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_px <= pos_x;
      s0_py <= pos_y;
      s0_pz <= pos_z;
      if (pos_z > 0)          s0_w <= pos_z[30:0];
      else if (near_w == '0)  s0_w <= WW'(1);
      else                    s0_w <= near_w;
    end
  end

  // stage 1: the four products
  logic signed [63:0] s1_ax, s1_bx, s1_ay, s1_by;
  logic [WW-1:0]      s1_w;
  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_ax <= 64'(s0_px) * 64'(x_scale);
      s1_bx <= 64'(s0_pz) * 64'(x_offset);
      s1_ay <= 64'(s0_py) * 64'(y_scale);
      s1_by <= 64'(s0_pz) * 64'(y_offset);
      s1_w  <= s0_w;
    end
  end

  // stage 2: sign and magnitude of each numerator, overflow check
  function automatic psp_div_t prep(input logic signed [63:0] a,
                                    input logic signed [63:0] b,
                                    input logic flip, input logic [WW-1:0] w);
    psp_div_t           o;
    logic signed [64:0] d;
    logic [63:0]        mag;
    logic [63-QB:0]     hi;
    d   = 65'(a) - 65'(b);
    mag = d[64] ? 64'(-d) : d[63:0];
    hi  = mag[63:QB];
    o.neg = d[64] ^ flip;
    o.ovf = ({1'b0, hi} >= w);
    o.r   = o.ovf ? '0 : WW'(hi);
    o.low = mag[QB-1:0];
    o.q   = '0;
    o.w   = w;
    return o;
  endfunction

  psp_div_t s2_x, s2_y, dx, dy;
  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_x <= prep(s1_ax, s1_bx, 1'b0, s1_w);
      s2_y <= prep(s1_ay, s1_by, 1'b1, s1_w);
    end
  end

  psp_divider u_div_x (.clk(clk), .en(en[3 +: QB]), .din(s2_x), .dout(dx));
  psp_divider u_div_y (.clk(clk), .en(en[3 +: QB]), .din(s2_y), .dout(dy));

  // scale stage: (vp + 1) * size
  function automatic logic signed [TW-1:0] scale_up(input psp_div_t d,
                                                    input logic [13:0] size);
    logic [QB-1:0]        qc;
    logic signed [QB:0]   vp;
    logic signed [QB+1:0] vpo;
    qc  = (d.ovf || d.q > Q_LIMIT) ? Q_LIMIT : d.q;
    vp  = d.neg ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
    vpo = (QB+2)'(vp) + ((QB+2)'(1) << FRAC_BITS);
    return TW'(vpo) * TW'($signed({1'b0, size}));
  endfunction

  localparam int SM = QB + 3;
  logic signed [TW-1:0] sm_tx, sm_ty;
  always_ff @(posedge clk) begin
    if (en[SM]) begin
      sm_tx <= scale_up(dx, screen_width);
      sm_ty <= scale_up(dy, screen_height);
    end
  end

  // halve, truncate toward zero, saturate
  function automatic logic signed [15:0] to_pixel(input logic signed [TW-1:0] t);
    logic [TW-1:0] tm;
    tm = t[TW-1] ? TW'(-t) : TW'(t);
    tm = tm >> (FRAC_BITS + 1);
    if (t[TW-1]) return (tm > TW'(32768)) ? 16'sh8000 : 16'(-tm);
    else         return (tm > TW'(32767)) ? 16'sh7fff : 16'(tm);
  endfunction

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      pixel_x <= to_pixel(sm_tx);
      pixel_y <= to_pixel(sm_ty);
    end
  end

endmodule
`default_nettype wire

[sv/psp_checker.sv]
// Port-level checks for the projection top level, with its bind.
// Depends on point_to_screen_projection_top ports only.
`default_nettype none
module psp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] pixel_x,
  input wire logic [15:0] pixel_y
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(pixel_x) && $stable(pixel_y))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

  a_empty_out_takes: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  a_free_out_takes: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("input stalled while output drains");

endmodule

bind point_to_screen_projection_top psp_checker u_psp_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .pixel_x(pixel_x), .pixel_y(pixel_y)
);
`default_nettype wire

[sim/psp_checker.sv]
// Scoreboard for the point to screen projection block: mirrors the config
// registers, predicts screen positions for accepted points, compares results.
// Depends on psp_pkg.
module psp_scoreboard import psp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_en,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] pixel_x,
  input  logic signed [15:0] pixel_y,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
  } pixel_t;

  logic signed [31:0] x_scale, x_offset, y_scale, y_offset;
  logic [30:0] near_w;
  logic [13:0] scr_w, scr_h;
  pixel_t pixel_q[$];

  function automatic logic signed [15:0] axis_pixel(
      longint scale, longint p, longint offset, longint z, longint w,
      bit flip, longint size);
    longint a, b, q, vp, t, r;
    bit neg;
    a = scale * p;
    b = offset * z;
    neg = (a < b);
    q = neg ? (b - a) : (a - b);
    if (flip) neg = !neg;
    q = q / w;
    if (q > (longint'(1) << (FRAC_BITS + 17))) q = longint'(1) << (FRAC_BITS + 17);
    vp = neg ? -q : q;
    t = (vp + (longint'(1) << FRAC_BITS)) * size;
    r = (t < 0) ? -((-t) >>> (FRAC_BITS + 1)) : (t >>> (FRAC_BITS + 1));
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  function automatic pixel_t project_point(logic signed [31:0] px,
      logic signed [31:0] py, logic signed [31:0] pz);
    pixel_t res;
    longint w;
    // points at or behind the camera use the near plane, zero counts as one LSB
    w = (pz > 0) ? longint'(pz) : ((near_w == 0) ? 1 : longint'(near_w));
    res.sx = axis_pixel(x_scale, px, x_offset, pz, w, 1'b0, scr_w);
    res.sy = axis_pixel(y_scale, py, y_offset, pz, w, 1'b1, scr_h);
    return res;
  endfunction

  assign pending = pixel_q.size();

  always @(posedge clk) begin
    pixel_t got, exp_px;
    if (rst) begin
      x_scale <= 32'sd65536; x_offset <= '0; y_scale <= 32'sd65536;
      y_offset <= '0; near_w <= 31'd6554; scr_w <= 14'd1920; scr_h <= 14'd1080;
      fail_count <= 0;
      pixel_q.delete();
    end else begin
      if (cfg_en) begin
        case (cfg_index)
          REG_X_SCALE:  x_scale  <= cfg_data;
          REG_X_OFFSET: x_offset <= cfg_data;
          REG_Y_SCALE:  y_scale  <= cfg_data;
          REG_Y_OFFSET: y_offset <= cfg_data;
          REG_NEAR_W:   near_w   <= cfg_data[30:0];
          REG_WIDTH:    scr_w    <= cfg_data[13:0];
          REG_HEIGHT:   scr_h    <= cfg_data[13:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) pixel_q.push_back(project_point(pos_x, pos_y, pos_z));
      if (out_valid && !out_stall) begin
        got.sx = pixel_x;
        got.sy = pixel_y;
        if (pixel_q.size() == 0) begin
          $display("%0t: unexpected result x=%0d y=%0d", $time, pixel_x, pixel_y);
          fail_count <= fail_count + 1;
        end else begin
          exp_px = pixel_q.pop_front();
          if (got !== exp_px) begin
            $display("%0t: mismatch expected x=%0d y=%0d actual x=%0d y=%0d", $time,
                     exp_px.sx, exp_px.sy, got.sx, got.sy);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

[sim/point_to_screen_projection_top_tb.sv]
// Testbench top for the point to screen projection block: config phases,
// directed and random points, idling and back-pressure. Depends on psp_scoreboard.
module point_to_screen_projection_top_tb import psp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0, rst = 1'b1;
  logic cfg_en = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0, out_stall = 1'b0;
  logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic in_stall, out_valid;
  logic signed [15:0] pixel_x, pixel_y;
  int fail_count, pending;
  int send_idle = 0, recv_idle = 0;
  bit hold_out = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  point_to_screen_projection_top u_dut (.*);
  psp_scoreboard u_chk (.*);

  initial begin
    #50ms;
    $display("TEST FAILED");
    $finish;
  end

  // receiver side: random stall, or a long hold-off when asked
  always @(posedge clk) begin
    if (hold_out) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_idle);
  end

  // enable stays up across back-to-back writes; the next point drops it
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_en <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    cfg_en <= 1'b0;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1; pos_x <= x; pos_y <= y; pos_z <= z;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    int n;
    n = 0;
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    while (n < 60) begin
      @(posedge clk);
      n++;
    end
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(4))
      0: return $urandom();
      1: return 32'($signed($urandom_range(20 << 16)) - (10 << 16));
      2: return 32'($urandom_range(3));
      default: return 32'($signed($urandom_range(200000)) - 100000);
    endcase
  endfunction

  function automatic logic [31:0] rand_depth();
    case ($urandom_range(4))
      0: return $urandom();
      1: return 32'(-$signed($urandom_range(5 << 16)));
      2: return 32'($urandom_range(3));
      default: return 32'($urandom_range(50 << 16, 1 << 14));
    endcase
  endfunction

  task automatic random_config();
    write_reg(REG_X_SCALE, ($urandom_range(3) == 0) ? $urandom() : $urandom_range(4 << 16));
    write_reg(REG_X_OFFSET, ($urandom_range(3) == 0) ? $urandom()
                            : 32'($signed($urandom_range(1 << 16)) - (1 << 15)));
    write_reg(REG_Y_SCALE, ($urandom_range(3) == 0) ? $urandom() : $urandom_range(4 << 16));
    write_reg(REG_Y_OFFSET, ($urandom_range(3) == 0) ? $urandom()
                            : 32'($signed($urandom_range(1 << 16)) - (1 << 15)));
    write_reg(REG_NEAR_W, $urandom());
    write_reg(REG_WIDTH, $urandom_range(16383));
    write_reg(REG_HEIGHT, $urandom_range(16383));
  endtask

  initial begin
    int k;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings, extremes, behind camera, zero depth
    send_point(0, 0, 32'sd65536);
    send_point(32'sh7fffffff, 32'sh80000000, 32'sd1);
    send_point(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
    send_point(32'sd65536, -32'sd65536, 0);
    send_point(32'sd1000, 32'sd1000, 32'sh80000000);
    send_point(32'sh7fffffff, 32'sh7fffffff, -32'sd1);
    send_point(32'hffffffff, 32'hffffffff, 32'sd65536);
    drain();
    // extreme registers: zero near plane and zero screen size
    write_reg(REG_X_SCALE, 32'h80000000);
    write_reg(REG_X_OFFSET, 32'h7fffffff);
    write_reg(REG_Y_SCALE, 32'h7fffffff);
    write_reg(REG_Y_OFFSET, 32'h80000000);
    write_reg(REG_NEAR_W, 32'd0);
    write_reg(REG_WIDTH, 32'd0);
    write_reg(REG_HEIGHT, 32'd8192);
    send_point(32'sd65536, 32'sd65536, 0);
    send_point(32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_point(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    send_point(32'sd3, -32'sd3, 32'sd1);
    drain();
    write_reg(REG_NEAR_W, 32'h7fffffff);
    write_reg(REG_WIDTH, 32'd16383);
    write_reg(REG_HEIGHT, 32'd1);
    send_point(32'sd65536, -32'sd65536, -32'sd65536);
    send_point(32'sh7fffffff, 32'sh80000000, 32'sh80000000);
    send_point(0, 0, 32'sd65536);
    drain();

    // random phases: sender light/receiver heavy, swap, then none
    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin send_idle = 7; recv_idle = 56; end
        1: begin send_idle = 56; recv_idle = 7; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      random_config();
      for (k = 0; k < 315; k++) begin
        if (ph == 4 && k == 20) begin
          // long output hold-off so the pipeline backs up into the input
          fork
            begin
              int c;
              hold_out = 1'b1;
              for (c = 0; c < 150; c++) @(posedge clk);
              hold_out = 1'b0;
            end
          join_none
        end
        send_point(rand_coord(), rand_coord(), rand_depth());
      end
      drain();
    end

    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
